### hdl/cpwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwe_pkg
// Shared types, codes and helpers for the cassette pulse-width encoder.
// ----------------------------------------------------------------------------
package cpwe_pkg;

   // Default longest pulse, in samples
   localparam int MAX_PULSE_SAMPLES_DEF = 8;

   // Register reset values
   localparam logic [3:0] LONG_RESET  = 4'd8;
   localparam logic [3:0] SHORT_RESET = 4'd4;
   localparam logic [6:0] AMP_RESET   = 7'd16;

   // CRC-16 constants
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Tape command codes
   typedef enum logic [2:0] {
      CMD_LEADER = 3'd0,
      CMD_SYNC   = 3'd1,
      CMD_PLAIN  = 3'd2,
      CMD_BLOCK  = 3'd3,
      CMD_CRC_HI = 3'd4,
      CMD_CRC_LO = 3'd5
   } cmd_code_type;

   // Register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_LONG  = 2'd0,
      CSR_SHORT = 2'd1,
      CSR_AMP   = 2'd2
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // take a new command
      logic step;   // produce one sample into the output register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;      // sample about to be produced ends the command
      logic out_free;  // output register can take a sample this cycle
   } dp_status_type;

   // One byte through CRC-16, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] value);
      logic [15:0] c;
      c = crc ^ {value, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### hdl/cpwe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwe_ctrl
// Command sequencer: accepts commands and paces the datapath one sample a step.
// ----------------------------------------------------------------------------
module cpwe_ctrl
   import cpwe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    command,
   output ctrl_cmd_type  dp_cmd,
   input  dp_status_type dp_status
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      accept;
   logic      cmd_valid;

   // Codes 6 and 7 are taken but produce nothing
   always_comb begin
      unique case (command)
         CMD_LEADER, CMD_SYNC, CMD_PLAIN,
         CMD_BLOCK, CMD_CRC_HI, CMD_CRC_LO: cmd_valid = 1'b1;
         default:                          cmd_valid = 1'b0;
      endcase
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign dp_cmd.load = accept;
   assign dp_cmd.step = (state_ff == ST_EMIT) && dp_status.out_free;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && cmd_valid) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (dp_cmd.step && dp_status.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // A known command blocks the input until its last sample is out
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      accept && cmd_valid |=> !req_tready)
      else $error("input still ready after a known command");

   // An unknown command leaves the input open
   a_idle_after_unknown: assert property (@(posedge clock) disable iff (reset)
      accept && !cmd_valid |=> req_tready)
      else $error("unknown command started emission");

   // Emission ends right after the final step
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.step && dp_status.last |=> req_tready)
      else $error("still busy after last sample");

endmodule

### hdl/cpwe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwe_dp
// Datapath: config registers, CRC, bit shifter, pulse counter, output register.
// ----------------------------------------------------------------------------
module cpwe_dp
   import cpwe_pkg::*;
#(
   parameter int MAX_PULSE_SAMPLES = MAX_PULSE_SAMPLES_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   // config
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [6:0]    csr_wdata,
   // command fields
   input  logic [2:0]    command,
   input  logic [7:0]    data_byte,
   input  logic          block_start,
   // control
   input  ctrl_cmd_type  dp_cmd,
   output dp_status_type dp_status,
   // result
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic          rsp_tlast
);

   localparam int LEN_W = $clog2(MAX_PULSE_SAMPLES + 1);
   localparam int POS_W = $clog2(MAX_PULSE_SAMPLES);

   logic [3:0]        long_ff;
   logic [3:0]        short_ff;
   logic [6:0]        amp_ff;
   logic [15:0]       crc_ff;
   logic [15:0]       crc_in;
   logic [7:0]        shift_ff;
   logic [7:0]        shift_in;
   logic [2:0]        bits_ff;
   logic [2:0]        bits_in;
   logic [POS_W-1:0]  pos_ff;
   logic [LEN_W-1:0]  lng;
   logic [LEN_W-1:0]  sht;
   logic [LEN_W-1:0]  cur_len;
   logic              pulse_end;
   logic signed [7:0] level_pos;
   logic signed [7:0] level_neg;
   logic signed [7:0] sample;
   logic              rsp_tvalid_ff;
   logic [7:0]        rsp_data_ff;
   logic              rsp_last_ff;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff  <= LONG_RESET;
         short_ff <= SHORT_RESET;
         amp_ff   <= AMP_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LONG:  long_ff  <= csr_wdata[3:0];
            CSR_SHORT: short_ff <= csr_wdata[3:0];
            CSR_AMP:   amp_ff   <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // Pulse lengths clamped to 2..MAX_PULSE_SAMPLES
   always_comb begin
      if (long_ff < 4'd2) begin
         lng = LEN_W'(2);
      end else if (int'(long_ff) > MAX_PULSE_SAMPLES) begin
         lng = LEN_W'(MAX_PULSE_SAMPLES);
      end else begin
         lng = LEN_W'(long_ff);
      end
      if (short_ff < 4'd2) begin
         sht = LEN_W'(2);
      end else if (int'(short_ff) > MAX_PULSE_SAMPLES) begin
         sht = LEN_W'(MAX_PULSE_SAMPLES);
      end else begin
         sht = LEN_W'(short_ff);
      end
   end

   // Load: pick the bits to send; block bytes advance the CRC
   always_comb begin
      crc_in   = crc_ff;
      shift_in = data_byte;
      bits_in  = 3'd7;
      unique case (command)
         CMD_LEADER: begin
            shift_in = 8'h80;
            bits_in  = 3'd0;
         end
         CMD_SYNC: begin
            shift_in = 8'h00;
            bits_in  = 3'd0;
         end
         CMD_PLAIN: ;
         CMD_BLOCK: crc_in = crc_feed(block_start ? CRC_INIT : crc_ff, data_byte);
         CMD_CRC_HI: shift_in = ~crc_ff[15:8];
         CMD_CRC_LO: shift_in = ~crc_ff[7:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else if (dp_cmd.load) begin
         crc_ff <= crc_in;
      end
   end

   // Current pulse and sample level
   assign cur_len   = shift_ff[7] ? lng : sht;
   assign pulse_end = (LEN_W'(pos_ff) == cur_len - LEN_W'(1));
   assign level_pos = {1'b0, amp_ff};
   assign level_neg = 8'd0 - level_pos;
   assign sample    = (LEN_W'(pos_ff) < (cur_len >> 1)) ? level_pos : level_neg;

   // Bit shifter and sample counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else if (dp_cmd.load) begin
         pos_ff   <= '0;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end else if (dp_cmd.step) begin
         if (pulse_end) begin
            pos_ff   <= '0;
            bits_ff  <= bits_ff - 3'd1;
            shift_ff <= {shift_ff[6:0], 1'b0};
         end else begin
            pos_ff <= pos_ff + POS_W'(1);
         end
      end
   end

   assign dp_status.last     = pulse_end && (bits_ff == 3'd0);
   assign dp_status.out_free = !rsp_tvalid_ff || rsp_tready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (dp_cmd.step) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.step) begin
         rsp_data_ff <= sample;
         rsp_last_ff <= dp_status.last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A step never overwrites a sample that has not been taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.step |-> dp_status.out_free)
      else $error("sample overwritten in output register");

   // Counter restarts at each new command
   a_load_clears_pos: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load |=> pos_ff == '0)
      else $error("pulse counter not cleared on load");

   // Mid-pulse steps count up by one
   a_pos_counts: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.step && !pulse_end && !dp_cmd.load |=> pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("pulse counter skipped");

   // Stepped sample lands in the output register with its end flag
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.step |=> rsp_tvalid && (rsp_tlast == $past(dp_status.last)))
      else $error("end-of-command flag lost");

endmodule

### hdl/cassette_pulse_width_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cassette_pulse_width_encoder
// Tape command to pulse-width coded audio sample stream, with block CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one tape command per beat; rsp channel returns one
//   signed sample per beat, tlast marking the final sample of each command.
//   A long pulse codes a one bit and leader, a short pulse a zero bit and
//   sync; bytes go MSB first. The first half of each pulse (rounded down) is
//   +amplitude, the rest -amplitude.
//   csr port sets long length, short length and amplitude; write it only
//   while no command is in progress.
// Timing:
//   The first sample is stepped once the controller enters its emit state
//   after the command beat, and is registered in the output register. Samples
//   follow at one per cycle while rsp_tready holds, set by the single pulse
//   counter; a command gives up to MAX_PULSE_SAMPLES samples for leader or
//   sync, up to 8 * MAX_PULSE_SAMPLES for a byte. Codes 6 and 7 are taken and produce nothing.
// Reset: lengths 8 and 4, amplitude 16, CRC 0xFFFF, output empty.
// Stall: when rsp_tready is low the sample holds and generation pauses; the
//   next command is accepted once the last sample sits in the output register.
// ----------------------------------------------------------------------------
module cassette_pulse_width_encoder
   import cpwe_pkg::*;
#(
   parameter int MAX_PULSE_SAMPLES = MAX_PULSE_SAMPLES_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   // command channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [3:0] req_tuser,   // [2:0] command, [3] block_start
   // sample channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] sample (signed)
   output logic       rsp_tlast,
   // config
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [6:0] csr_wdata
);

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_status;

   cpwe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser[2:0]),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   cpwe_dp #(
      .MAX_PULSE_SAMPLES (MAX_PULSE_SAMPLES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .command     (req_tuser[2:0]),
      .data_byte   (req_tdata),
      .block_start (req_tuser[3]),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### tb/sv/cpwe_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwe_sample_checker
// Watches the command, sample and csr ports of the cassette pulse-width
// encoder. It keeps its own copy of the pulse lengths, amplitude and block
// CRC, expands every accepted command into the samples it must produce and
// compares each sample beat, level and tlast, against the oldest expected one.
// ----------------------------------------------------------------------------
module cpwe_sample_checker
   import cpwe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [3:0] req_tuser,   // [2:0] command, [3] block_start
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] sample (signed)
   input  logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [6:0] csr_wdata,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic [7:0] level;
      logic       tail;
   } tape_sample_type;

   tape_sample_type tape_samples[$];
   tape_sample_type head;

   logic [3:0]  long_reg;
   logic [3:0]  short_reg;
   logic [6:0]  amp_reg;
   logic [15:0] block_crc;
   int          beat_no;

   // pulse length register as the block uses it
   function automatic int pulse_samples(input logic [3:0] setting);
      if (setting < 4'd2) return 2;
      if (int'(setting) > MAX_PULSE_SAMPLES_DEF) return MAX_PULSE_SAMPLES_DEF;
      return int'(setting);
   endfunction

   // bit-serial CRC-16, data MSB first
   function automatic logic [15:0] crc_after(input logic [15:0] seed,
                                             input logic [7:0]  value);
      logic [15:0] c;
      logic        fb;
      c = seed;
      for (int b = 7; b >= 0; b--) begin
         fb = c[15] ^ value[b];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // one pulse: floor(len/2) samples high, the rest low
   task automatic queue_pulse(input int len);
      tape_sample_type s;
      logic [7:0]      hi;
      logic [7:0]      lo;
      hi = {1'b0, amp_reg};
      lo = ~hi + 8'd1;
      for (int i = 0; i < len; i++) begin
         s.level = (i < len / 2) ? hi : lo;
         s.tail  = 1'b0;
         tape_samples.push_back(s);
      end
   endtask

   // eight pulses, MSB first: one is long, zero is short
   task automatic queue_byte(input logic [7:0] value);
      for (int b = 7; b >= 0; b--) begin
         queue_pulse(value[b] ? pulse_samples(long_reg) : pulse_samples(short_reg));
      end
   endtask

   // expected samples of one command beat
   task automatic expand_command(input logic [2:0] code, input logic [7:0] data,
                                 input logic start);
      int          first;
      logic [15:0] inv;
      first = tape_samples.size();
      inv   = ~block_crc;
      case (code)
         CMD_LEADER: queue_pulse(pulse_samples(long_reg));
         CMD_SYNC:   queue_pulse(pulse_samples(short_reg));
         CMD_PLAIN:  queue_byte(data);
         CMD_BLOCK: begin
            if (start) block_crc = CRC_INIT;
            block_crc = crc_after(block_crc, data);
            queue_byte(data);
         end
         CMD_CRC_HI: queue_byte(inv[15:8]);
         CMD_CRC_LO: queue_byte(inv[7:0]);
         default: ;  // unused codes give nothing
      endcase
      if (tape_samples.size() > first) begin
         tape_samples[tape_samples.size() - 1].tail = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at sample beat %0d: %s got 0x%02h want 0x%02h",
               beat_no, what, got, want);
      fail_count++;
   endtask

   // all ports sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         tape_samples.delete();
         long_reg   = LONG_RESET;
         short_reg  = SHORT_RESET;
         amp_reg    = AMP_RESET;
         block_crc  = CRC_INIT;
         fail_count = 0;
         beat_no    = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_LONG:  long_reg  = csr_wdata[3:0];
               CSR_SHORT: short_reg = csr_wdata[3:0];
               CSR_AMP:   amp_reg   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (tape_samples.size() == 0) begin
               report_mismatch("unexpected sample", rsp_tdata, 8'h00);
            end else begin
               head = tape_samples.pop_front();
               if (rsp_tdata !== head.level) report_mismatch("sample", rsp_tdata, head.level);
               if (rsp_tlast !== head.tail) report_mismatch("tlast", {7'd0, rsp_tlast},
                                                            {7'd0, head.tail});
            end
            beat_no++;
         end
         if (req_tvalid && req_tready) begin
            expand_command(req_tuser[2:0], req_tdata, req_tuser[3]);
         end
      end
      pending = tape_samples.size();
   end

endmodule

### tb/sv/tb_cassette_pulse_width_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cassette_pulse_width_encoder
// Drives tape commands and csr writes into the encoder, with random gaps on
// both channels, a long sample-side stall and several pulse/amplitude
// settings; the sample checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_cassette_pulse_width_encoder
   import cpwe_pkg::*;
();

   localparam int          DRAIN_CYCLES   = 20;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [2:0]  CMD_UNUSED_6   = 3'd6;
   localparam logic [2:0]  CMD_UNUSED_7   = 3'd7;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic [3:0] req_tuser;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_we;
   logic [1:0] csr_addr;
   logic [6:0] csr_wdata;

   int fail_count;
   int pending;
   int send_idle;
   int recv_idle;
   int hold_asks;
   int holds_begun;
   int stall_cycles;

   always #1 clock = ~clock;

   cassette_pulse_width_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   cpwe_sample_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // sample side: random backpressure, or a long hold when asked
   initial begin
      int hold_left;
      hold_left   = 0;
      holds_begun = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_begun != hold_asks) begin
            holds_begun++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   // watchdog: too long without a command beat
   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (req_tvalid && req_tready) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // one command beat; called and returns at a falling edge
   task automatic send_beat(input logic [2:0] code, input logic [7:0] data,
                            input logic start);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = {start, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [6:0] value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // wait for every sample, then let the block settle
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_setting(input logic [3:0] lng, input logic [3:0] sht,
                               input logic [6:0] amp);
      drain();
      write_reg(CSR_LONG,  {3'd0, lng});
      write_reg(CSR_SHORT, {3'd0, sht});
      write_reg(CSR_AMP,   amp);
   endtask

   // mostly whole tape records (leader, sync, block, CRC), some loose commands
   task automatic send_records(input int count);
      int         sent;
      int         pick;
      int         nbytes;
      logic [2:0] code;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 3)) send_beat(CMD_LEADER, 8'($urandom), 1'($urandom));
            send_beat(CMD_SYNC, 8'($urandom), 1'($urandom));
            nbytes = $urandom_range(1, 6);
            for (int i = 0; i < nbytes; i++) begin
               send_beat(CMD_BLOCK, 8'($urandom), (i == 0));
            end
            send_beat(CMD_CRC_HI, 8'($urandom), 1'($urandom));
            send_beat(CMD_CRC_LO, 8'($urandom), 1'($urandom));
            sent += nbytes + 4;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10)      code = CMD_LEADER;
            else if (pick < 20) code = CMD_SYNC;
            else if (pick < 45) code = CMD_PLAIN;
            else if (pick < 70) code = CMD_BLOCK;
            else if (pick < 80) code = CMD_CRC_HI;
            else if (pick < 90) code = CMD_CRC_LO;
            else if (pick < 95) code = CMD_UNUSED_6;
            else                code = CMD_UNUSED_7;
            send_beat(code, 8'($urandom), ($urandom_range(0, 3) == 0));
            if (code != CMD_UNUSED_6 && code != CMD_UNUSED_7) sent++;
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 4'h0;
      csr_we     = 1'b0;
      csr_addr   = CSR_LONG;
      csr_wdata  = 7'd0;
      send_idle  = 10;
      recv_idle  = 56;
      hold_asks  = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed: shortest short pulse, full swing
      load_setting(4'd8, 4'd2, 7'd127);
      send_beat(CMD_LEADER, 8'hFF, 1'b1);   // data and block_start ignored
      send_beat(CMD_SYNC, 8'h00, 1'b1);
      send_beat(CMD_PLAIN, 8'h00, 1'b0);
      send_beat(CMD_PLAIN, 8'hFF, 1'b0);
      send_beat(CMD_PLAIN, 8'h5A, 1'b1);    // block_start has no effect here
      send_beat(CMD_BLOCK, 8'hA5, 1'b1);
      send_beat(CMD_BLOCK, 8'h3C, 1'b0);
      send_beat(CMD_CRC_HI, 8'h00, 1'b0);
      send_beat(CMD_CRC_LO, 8'hFF, 1'b1);
      send_beat(CMD_CRC_HI, 8'h00, 1'b0);   // CRC unchanged by CRC commands
      send_beat(CMD_UNUSED_6, 8'hFF, 1'b1);
      send_beat(CMD_UNUSED_7, 8'h00, 1'b0);
      send_beat(CMD_BLOCK, 8'hFF, 1'b0);
      send_beat(CMD_BLOCK, 8'h00, 1'b1);    // reload mid-stream
      send_beat(CMD_CRC_LO, 8'h00, 1'b0);
      send_beat(CMD_CRC_HI, 8'h00, 1'b0);
      send_beat(CMD_LEADER, 8'h00, 1'b0);

      // lengths outside 2..MAX and zero amplitude
      load_setting(4'd0, 4'd15, 7'd0);
      send_beat(CMD_LEADER, 8'h00, 1'b0);
      send_beat(CMD_SYNC, 8'h00, 1'b0);
      send_beat(CMD_PLAIN, 8'hC3, 1'b0);
      send_records(22);

      // slow sender, eager receiver
      send_idle = 56;
      recv_idle = 10;
      load_setting(4'd2, 4'd8, 7'd1);
      send_records(25);
      load_setting(4'($urandom), 4'($urandom), 7'($urandom));
      send_records(25);

      // no gaps: long sample stall with commands still offered
      send_idle = 0;
      recv_idle = 0;
      load_setting(4'd15, 4'd1, 7'd64);
      hold_asks++;
      send_records(10);
      drain();
      send_records(15);
      load_setting(LONG_RESET, SHORT_RESET, AMP_RESET);
      send_records(25);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
